// File: sv/chunked_sparse_value_map_assert.svh
// Assertion macros for the chunked sparse value map.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef CHUNKED_SPARSE_VALUE_MAP_ASSERT_SVH
`define CHUNKED_SPARSE_VALUE_MAP_ASSERT_SVH

`ifndef SYNTHESIS

`define CSVM_ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("csvm: same-cycle check failed");

`define CSVM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("csvm: next-cycle check failed");

`else

`define CSVM_ASSERT_SAME(label, clk, rst_n, cond, cons)

`define CSVM_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

// File: sv/csvm_pkg.sv
package csvm_pkg;

	localparam int VAL_W       = 16;
	localparam int OFS_W       = 8;
	localparam int ENTRY_W     = 24;
	localparam int LEN_W       = 17;
	localparam int CHUNK_SPAN  = 256;
	localparam int MAX_CHUNKS  = 256;

	localparam logic [VAL_W-1:0] ABSENT    = 16'hFFFF;
	localparam logic [LEN_W-1:0] LEN_RESET = 17'h10000;

	localparam int NUM_CHUNKS_DEF  = 256;
	localparam int CHUNK_SLOTS_DEF = 64;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_ERASE = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CNT,
		S_SEARCH,
		S_ACT,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [VAL_W-1:0] index;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic [1:0]       status;
	} rsp_t;

	// Chunks beyond the reach of a 16-bit index are never addressed.
	function automatic int eff_chunks(input int n);
		return (n > MAX_CHUNKS) ? MAX_CHUNKS : n;
	endfunction

	function automatic int width_of(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// File: sv/csvm_entry_ram.sv
module csvm_entry_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [csvm_pkg::ENTRY_W-1:0] wdata,
	input  logic [AW-1:0]                raddr,
	output logic [csvm_pkg::ENTRY_W-1:0] rdata
);

	logic [csvm_pkg::ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/csvm_count_store.sv
module csvm_count_store #(
	parameter int NCH = 256,
	parameter int CW  = 8,
	parameter int SW  = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [CW-1:0] waddr,
	input  logic [SW-1:0] wdata,
	input  logic [CW-1:0] raddr,
	output logic [SW-1:0] rdata
);

	logic [SW-1:0]  mem [NCH];
	logic [NCH-1:0] valid_q;
	logic [SW-1:0]  rdata_q;
	logic           rvalid_q;

	// A chunk that was never written since reset reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvalid_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// File: sv/csvm_ctrl.sv
module csvm_ctrl #(
	parameter int NUM_CHUNKS  = 256,
	parameter int CHUNK_SLOTS = 64,
	parameter int CW          = 8,
	parameter int SW          = 7,
	parameter int AW          = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  csvm_pkg::req_t               req,
	input  logic [csvm_pkg::LEN_W-1:0]   len,
	output logic [CW-1:0]                cnt_raddr,
	input  logic [SW-1:0]                cnt_rdata,
	output logic                         cnt_we,
	output logic [CW-1:0]                cnt_waddr,
	output logic [SW-1:0]                cnt_wdata,
	output logic [AW-1:0]                ent_raddr,
	input  logic [csvm_pkg::ENTRY_W-1:0] ent_rdata,
	output logic                         ent_we,
	output logic [AW-1:0]                ent_waddr,
	output logic [csvm_pkg::ENTRY_W-1:0] ent_wdata,
	output logic                         res_valid,
	output csvm_pkg::rsp_t               res,
	input  logic                         res_take
);

	csvm_pkg::state_t                  state_q, state_d;
	logic                              pend_q, pend_d;
	logic [1:0]                        op_q, op_d;
	logic [csvm_pkg::OFS_W-1:0]        ofs_q, ofs_d;
	logic [csvm_pkg::VAL_W-1:0]        val_q, val_d;
	logic [CW-1:0]                     chunk_q, chunk_d;
	logic [AW-1:0]                     base_q, base_d;
	logic [SW-1:0]                     cnt_q, cnt_d;
	logic [SW-1:0]                     rd_ptr_q, rd_ptr_d;
	logic [SW-1:0]                     pend_slot_q, pend_slot_d;
	logic [SW-1:0]                     slot_q, slot_d;
	logic                              found_q, found_d;
	logic [csvm_pkg::VAL_W-1:0]        got_q, got_d;
	csvm_pkg::status_t                 status_q, status_d;
	logic                              out_of_range;

	assign out_of_range = ({1'b0, req.index} >= len)
		|| (32'(req.index[csvm_pkg::VAL_W-1:csvm_pkg::OFS_W]) >= NUM_CHUNKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csvm_pkg::S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q        <= op_d;
		ofs_q       <= ofs_d;
		val_q       <= val_d;
		chunk_q     <= chunk_d;
		base_q      <= base_d;
		cnt_q       <= cnt_d;
		rd_ptr_q    <= rd_ptr_d;
		pend_slot_q <= pend_slot_d;
		slot_q      <= slot_d;
		found_q     <= found_d;
		got_q       <= got_d;
		status_q    <= status_d;
	end

	always_comb begin
		state_d     = state_q;
		pend_d      = pend_q;
		op_d        = op_q;
		ofs_d       = ofs_q;
		val_d       = val_q;
		chunk_d     = chunk_q;
		base_d      = base_q;
		cnt_d       = cnt_q;
		rd_ptr_d    = rd_ptr_q;
		pend_slot_d = pend_slot_q;
		slot_d      = slot_q;
		found_d     = found_q;
		got_d       = got_q;
		status_d    = status_q;

		req_stall = (state_q != csvm_pkg::S_IDLE);
		cnt_raddr = req.index[csvm_pkg::OFS_W +: CW];
		cnt_we    = 1'b0;
		cnt_waddr = chunk_q;
		cnt_wdata = cnt_q;
		ent_raddr = base_q + AW'(rd_ptr_q);
		ent_we    = 1'b0;
		ent_waddr = base_q + AW'(slot_q);
		ent_wdata = {ofs_q, val_q};
		res_valid = 1'b0;

		unique case (state_q)
			csvm_pkg::S_IDLE: begin
				if (req_valid) begin
					op_d    = req.operation;
					ofs_d   = req.index[csvm_pkg::OFS_W-1:0];
					val_d   = req.value;
					chunk_d = req.index[csvm_pkg::OFS_W +: CW];
					base_d  = AW'(32'(req.index[csvm_pkg::OFS_W +: CW]) * CHUNK_SLOTS);
					if (out_of_range) begin
						got_d    = csvm_pkg::ABSENT;
						status_d = csvm_pkg::ST_RANGE;
						state_d  = csvm_pkg::S_DONE;
					end else begin
						state_d = csvm_pkg::S_CNT;
					end
				end
			end
			csvm_pkg::S_CNT: begin
				cnt_d    = cnt_rdata;
				rd_ptr_d = '0;
				pend_d   = 1'b0;
				found_d  = 1'b0;
				got_d    = csvm_pkg::ABSENT;
				status_d = csvm_pkg::ST_OK;
				state_d  = csvm_pkg::S_SEARCH;
			end
			csvm_pkg::S_SEARCH: begin
				// Reads are issued one slot ahead of the compare.
				if (pend_q && (ent_rdata[csvm_pkg::ENTRY_W-1:csvm_pkg::VAL_W] == ofs_q)) begin
					found_d = 1'b1;
					slot_d  = pend_slot_q;
					got_d   = ent_rdata[csvm_pkg::VAL_W-1:0];
					pend_d  = 1'b0;
					state_d = csvm_pkg::S_ACT;
				end else if (rd_ptr_q < cnt_q) begin
					pend_d      = 1'b1;
					pend_slot_d = rd_ptr_q;
					rd_ptr_d    = rd_ptr_q + SW'(1);
				end else if (pend_q) begin
					pend_d = 1'b0;
				end else begin
					state_d = csvm_pkg::S_ACT;
				end
			end
			csvm_pkg::S_ACT: begin
				rd_ptr_d = slot_q + SW'(1);
				pend_d   = 1'b0;
				state_d  = csvm_pkg::S_DONE;
				unique case (op_q)
					csvm_pkg::OP_WRITE: begin
						if (got_q == val_q) begin
							state_d = csvm_pkg::S_DONE;
						end else if (val_q == csvm_pkg::ABSENT) begin
							state_d = csvm_pkg::S_SHIFT;
						end else if (found_q) begin
							ent_we = 1'b1;
						end else if (cnt_q >= SW'(CHUNK_SLOTS)) begin
							status_d = csvm_pkg::ST_FULL;
						end else begin
							ent_we    = 1'b1;
							ent_waddr = base_q + AW'(cnt_q);
							cnt_we    = 1'b1;
							cnt_wdata = cnt_q + SW'(1);
						end
					end
					csvm_pkg::OP_ERASE: begin
						if (found_q) begin
							state_d = csvm_pkg::S_SHIFT;
						end else begin
							status_d = csvm_pkg::ST_ABSENT;
						end
					end
					default: begin
						state_d = csvm_pkg::S_DONE;
					end
				endcase
			end
			csvm_pkg::S_SHIFT: begin
				// Entry j is written to slot j-1 in the cycle after it is read.
				if (pend_q) begin
					ent_we    = 1'b1;
					ent_waddr = base_q + AW'(pend_slot_q - SW'(1));
					ent_wdata = ent_rdata;
				end
				if (rd_ptr_q < cnt_q) begin
					pend_d      = 1'b1;
					pend_slot_d = rd_ptr_q;
					rd_ptr_d    = rd_ptr_q + SW'(1);
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						cnt_we    = 1'b1;
						cnt_wdata = cnt_q - SW'(1);
						state_d   = csvm_pkg::S_DONE;
					end
				end
			end
			csvm_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = csvm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = csvm_pkg::S_IDLE;
			end
		endcase
	end

	assign res.read_value = got_q;
	assign res.status     = status_q;

endmodule

// File: sv/chunked_sparse_value_map.sv
// Chunked sparse value map: one request in, one response out.
// A read or write walks the entries held in the addressed chunk; an erase, or a write of the
// absent value, that finds its entry walks the later entries again to move them down by one.
// The sequencer handles one request at a time.
// Reset (arst_n, asynchronous, active low) empties every chunk and sets the length to 65536.
module chunked_sparse_value_map #(
	parameter int NUM_CHUNKS  = csvm_pkg::NUM_CHUNKS_DEF,
	parameter int CHUNK_SLOTS = csvm_pkg::CHUNK_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  csvm_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output csvm_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [csvm_pkg::LEN_W-1:0] cfg_wdata
);

	// Only the chunks that a 16-bit index can reach are given storage. Each chunk owns
	// CHUNK_SLOTS consecutive words of the entry memory, and one word of the count store.
	localparam int NCH   = csvm_pkg::eff_chunks(NUM_CHUNKS);
	localparam int CW    = csvm_pkg::width_of(NCH);
	localparam int SW    = $clog2(CHUNK_SLOTS + 1);
	localparam int DEPTH = NCH * CHUNK_SLOTS;
	localparam int AW    = csvm_pkg::width_of(DEPTH);

	logic [csvm_pkg::LEN_W-1:0]   len_q;
	logic [CW-1:0]                cnt_raddr;
	logic [SW-1:0]                cnt_rdata;
	logic                         cnt_we;
	logic [CW-1:0]                cnt_waddr;
	logic [SW-1:0]                cnt_wdata;
	logic [AW-1:0]                ent_raddr;
	logic [csvm_pkg::ENTRY_W-1:0] ent_rdata;
	logic                         ent_we;
	logic [AW-1:0]                ent_waddr;
	logic [csvm_pkg::ENTRY_W-1:0] ent_wdata;
	logic                         res_valid;
	csvm_pkg::rsp_t               res;
	logic                         res_take;
	logic                         rsp_valid_q;
	csvm_pkg::rsp_t               rsp_q;
	logic                         rsp_is_range;
	logic                         rsp_is_missing;
	logic                         rsp_is_absent;

	// The length register is only to be written while the block is idle; the block itself
	// does not enforce this. So the sequencer may read it directly when a request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= csvm_pkg::LEN_RESET;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	// The sequencer walks the chunk one slot per cycle for the search and, when an erase or a
	// write of the absent value finds its entry, again to move the later entries down by one.
	csvm_ctrl #(
		.NUM_CHUNKS  (NUM_CHUNKS),
		.CHUNK_SLOTS (CHUNK_SLOTS),
		.CW          (CW),
		.SW          (SW),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.len       (len_q),
		.cnt_raddr (cnt_raddr),
		.cnt_rdata (cnt_rdata),
		.cnt_we    (cnt_we),
		.cnt_waddr (cnt_waddr),
		.cnt_wdata (cnt_wdata),
		.ent_raddr (ent_raddr),
		.ent_rdata (ent_rdata),
		.ent_we    (ent_we),
		.ent_waddr (ent_waddr),
		.ent_wdata (ent_wdata),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	// Per-chunk entry counts; a chunk untouched since reset reads as empty.
	csvm_count_store #(
		.NCH (NCH),
		.CW  (CW),
		.SW  (SW)
	) u_counts (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cnt_we),
		.waddr  (cnt_waddr),
		.wdata  (cnt_wdata),
		.raddr  (cnt_raddr),
		.rdata  (cnt_rdata)
	);

	// Packed (offset, value) entries. Slots at or above a chunk's count are never read,
	// so the memory needs no clearing after reset.
	csvm_entry_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_entries (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// Output register: a finished response waits here for its transfer, and the
	// sequencer may already have taken the next request.
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rsp_is_range   = rsp_valid && (rsp.status == csvm_pkg::ST_RANGE);
	assign rsp_is_missing = rsp_valid && (rsp.status == csvm_pkg::ST_ABSENT);
	assign rsp_is_absent  = (rsp.read_value == csvm_pkg::ABSENT);

	`include "chunked_sparse_value_map_assert.svh"

	// Once a request is taken the block stays busy for at least the count lookup.
	`CSVM_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && !req_stall, req_stall)

	// A rejected index never reports a stored value.
	`CSVM_ASSERT_SAME(a_range_absent, clk, arst_n, rsp_is_range, rsp_is_absent)

	// Erasing a missing entry reports the absent value.
	`CSVM_ASSERT_SAME(a_erase_absent, clk, arst_n, rsp_is_missing, rsp_is_absent)

	// A chunk never holds more entries than it has slots.
	`CSVM_ASSERT_SAME(a_count_bound, clk, arst_n, cnt_we, cnt_wdata <= SW'(CHUNK_SLOTS))

endmodule
